// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assertion clocked on clk, disabled while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion with an explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, c, r, prop, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, c, r, prop, msg)
`endif
`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Package with the codes and state type of the buddy page allocator.
package bpa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_NOTHEAD = 2'd2,
        ST_BADARG  = 2'd3
    } status_t;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_TOPS  = 1'b1;

    localparam int          CNT_W   = 13;
    localparam logic [12:0] CNT_MAX = 13'd8191;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_SEL   = 9'b000001000,
        S_SPLIT = 9'b000010000,
        S_FCHK  = 9'b000100000,
        S_MREAD = 9'b001000000,
        S_MWAIT = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/buddy_page_allocator_core.sv =====
// Top level of the buddy page allocator: sequencer around two page-indexed RAMs.
//
//  Channel   Direction  Signals                                   Transaction
//  request   in         start, busy, op, order, page_number       start & !busy
//  result    out        done, status, alloc_page, free_pages_total done (one cycle)
//  config    in         cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// An allocation scans the head-order RAM one page per cycle over the live pool;
// the single read port of that RAM sets that rate. A free does one RAM read
// and one check per merge level. A reinitialise request, and reset, sweep all
// POOL_PAGES entries of both RAMs, one entry per cycle, and the block is busy
// for that time. Requests rejected for a bad argument answer from idle in the
// next cycle. The result is shown for exactly one cycle with done high; the
// receiver cannot stall it.
`include "assert_macros.svh"
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int MAX_ORDER  = 4,
    parameter int POOL_PAGES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  order,
    input  logic [19:0] page_number,
    output logic        done,
    output logic [1:0]  status,
    output logic [19:0] alloc_page,
    output logic [12:0] free_pages_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    // Index into the pool, a page count that can hold the pool size, and the
    // width of a stored head order, which includes one code for "not free".
    localparam int IDX_W = $clog2(POOL_PAGES);
    localparam int LIV_W = IDX_W + 1;
    localparam int ORD_W = $clog2(MAX_ORDER + 2);
    localparam logic [ORD_W-1:0] NOT_FREE = {ORD_W{1'b1}};
    localparam logic [ORD_W-1:0] TOP_ORD  = ORD_W'(MAX_ORDER);
    localparam int TOPS_MAX  = POOL_PAGES >> MAX_ORDER;
    localparam int RST_TOPS  = (256 > TOPS_MAX) ? TOPS_MAX : 256;
    localparam int RST_LIVE  = RST_TOPS << MAX_ORDER;
    localparam int RST_FREE  = (RST_LIVE > 8191) ? 8191 : RST_LIVE;
    localparam logic [LIV_W-1:0] LAST_PAGE = LIV_W'(POOL_PAGES - 1);
    localparam logic [LIV_W-1:0] TOP_MASK  = LIV_W'((1 << MAX_ORDER) - 1);

    // Configuration registers; they take effect at reset and at reinitialise.
    logic [19:0] cfg_start_reg;
    logic [8:0]  cfg_tops_reg;

    // Latched pool bounds and the free page counter.
    logic [19:0]       live_start_reg;
    logic [LIV_W-1:0]  live_pages_reg;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;

    state_t            state_reg, state_next;
    logic [LIV_W-1:0]  ptr_reg, ptr_next;
    logic              rvld_reg, rvld_next;
    logic [IDX_W-1:0]  rq_reg, rq_next;
    logic              pend_reg, pend_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [ORD_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Scan trackers: lowest free head of every order and highest of the asked order.
    logic [MAX_ORDER:0] lo_fnd_reg, lo_fnd_next;
    logic [IDX_W-1:0]   lo_idx_reg [0:MAX_ORDER];
    logic [IDX_W-1:0]   lo_idx_next [0:MAX_ORDER];
    logic [IDX_W-1:0]   hi_idx_reg, hi_idx_next;

    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [19:0]       page_reg, page_next;

    // RAM ports.
    logic              fho_we, al_we;
    logic [IDX_W-1:0]  fho_waddr, fho_raddr, al_waddr, al_raddr;
    logic [ORD_W-1:0]  fho_wdata, fho_rdata;
    logic              al_wdata, al_rdata;

    // Bounds taken at a reinitialise request.
    logic [8:0]        tops_clamped;
    logic [LIV_W-1:0]  new_live;

    // Free request checks.
    logic [20:0]       f_off;
    logic              f_ok;
    logic [20:0]       f_mask;

    // Selection after the scan.
    logic              sel_fnd;
    logic [ORD_W-1:0]  sel_ord;
    logic [IDX_W-1:0]  sel_idx;

    // Split and merge addressing.
    logic [ORD_W-1:0]  cm1;
    logic [LIV_W-1:0]  split_b;
    logic [LIV_W-1:0]  bud;
    logic [13:0]       blk_pages;
    logic [13:0]       cnt_sum;

    bpa_ram #(.WIDTH(ORD_W), .DEPTH(POOL_PAGES)) u_fho_ram (
        .clk   (clk),
        .we    (fho_we),
        .waddr (fho_waddr),
        .wdata (fho_wdata),
        .raddr (fho_raddr),
        .rdata (fho_rdata)
    );

    bpa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES)) u_alloc_ram (
        .clk   (clk),
        .we    (al_we),
        .waddr (al_waddr),
        .wdata (al_wdata),
        .raddr (al_raddr),
        .rdata (al_rdata)
    );

    assign busy             = (state_reg != S_IDLE);
    assign cfg_ready        = 1'b1;
    assign done             = done_reg;
    assign status           = status_reg;
    assign alloc_page       = page_reg;
    assign free_pages_total = free_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_start_reg <= 20'd0;
            cfg_tops_reg  <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START: cfg_start_reg <= cfg_data;
                CFG_TOPS:  cfg_tops_reg  <= cfg_data[8:0];
                default:   cfg_start_reg <= cfg_start_reg;
            endcase
        end
    end

    always_comb
    begin
        tops_clamped = (32'(cfg_tops_reg) > TOPS_MAX) ? 9'(TOPS_MAX) : cfg_tops_reg;
        new_live     = LIV_W'(32'(tops_clamped) << MAX_ORDER);
    end

    // Free request checks against the live pool.
    always_comb
    begin
        f_off  = {1'b0, page_number} - {1'b0, live_start_reg};
        f_mask = (21'd1 << order) - 21'd1;
        f_ok   = (page_number >= live_start_reg)
                 && (f_off < 21'(live_pages_reg))
                 && ((f_off & f_mask) == 21'd0);
    end

    // Pick the smallest order at or above the asked one that has a free head.
    // At the asked order above zero the highest head is taken, else the lowest.
    always_comb
    begin
        sel_fnd = 1'b0;
        sel_ord = ord_reg;
        sel_idx = lo_idx_reg[0];
        for (int o = MAX_ORDER; o >= 0; o--)
        begin
            if ((ORD_W'(o) >= ord_reg) && lo_fnd_reg[o])
            begin
                sel_fnd = 1'b1;
                sel_ord = ORD_W'(o);
                sel_idx = ((ORD_W'(o) == ord_reg) && (ord_reg != '0)) ? hi_idx_reg
                                                                      : lo_idx_reg[o];
            end
        end
    end

    always_comb
    begin
        cm1       = cur_reg - ORD_W'(1);
        split_b   = {1'b0, idx_reg} + (LIV_W'(1) << cm1);
        bud       = {1'b0, idx_reg} ^ (LIV_W'(1) << cur_reg);
        blk_pages = 14'd1 << ord_reg;
        cnt_sum   = {1'b0, free_cnt_reg} + blk_pages;
    end

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        rvld_next   = 1'b0;
        rq_next     = rq_reg;
        pend_next   = pend_reg;
        ord_next    = ord_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        lo_fnd_next = lo_fnd_reg;
        lo_idx_next = lo_idx_reg;
        hi_idx_next = hi_idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        page_next   = page_reg;
        free_cnt_next = free_cnt_reg;

        fho_we    = 1'b0;
        fho_waddr = idx_reg;
        fho_wdata = NOT_FREE;
        fho_raddr = ptr_reg[IDX_W-1:0];
        al_we     = 1'b0;
        al_waddr  = idx_reg;
        al_wdata  = 1'b0;
        al_raddr  = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                al_raddr = f_off[IDX_W-1:0];
                if (start)
                begin
                    ord_next = ORD_W'(order);
                    if (op == OP_REINIT)
                    begin
                        // Latch the new bounds and sweep both RAMs.
                        ptr_next   = '0;
                        pend_next  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else if ((op == OP_BAD) || (32'(order) > MAX_ORDER))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BADARG;
                        page_next   = 20'd0;
                    end
                    else if (op == OP_ALLOC)
                    begin
                        ptr_next    = '0;
                        lo_fnd_next = '0;
                        state_next  = S_SCAN;
                    end
                    else if (!f_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BADARG;
                        page_next   = 20'd0;
                    end
                    else
                    begin
                        idx_next   = f_off[IDX_W-1:0];
                        state_next = S_FCHK;
                    end
                end
            end

            S_CLEAR:
            begin
                fho_we    = 1'b1;
                fho_waddr = ptr_reg[IDX_W-1:0];
                fho_wdata = ((ptr_reg < live_pages_reg) && ((ptr_reg & TOP_MASK) == '0))
                            ? TOP_ORD : NOT_FREE;
                al_we     = 1'b1;
                al_waddr  = ptr_reg[IDX_W-1:0];
                al_wdata  = 1'b0;
                ptr_next  = ptr_reg + LIV_W'(1);
                if (ptr_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                    pend_next  = 1'b0;
                    if (pend_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        page_next   = 20'd0;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle and fold the returning entry.
                if (ptr_reg < live_pages_reg)
                begin
                    rvld_next = 1'b1;
                    rq_next   = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + LIV_W'(1);
                end
                else if (!rvld_reg)
                begin
                    state_next = S_SEL;
                end
                if (rvld_reg)
                begin
                    for (int o = 0; o <= MAX_ORDER; o++)
                    begin
                        if ((fho_rdata == ORD_W'(o)) && !lo_fnd_reg[o])
                        begin
                            lo_fnd_next[o] = 1'b1;
                            lo_idx_next[o] = rq_reg;
                        end
                    end
                    if (fho_rdata == ord_reg)
                    begin
                        hi_idx_next = rq_reg;
                    end
                end
            end

            S_SEL:
            begin
                if (!sel_fnd)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOFREE;
                    page_next   = 20'd0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    fho_we    = 1'b1;
                    fho_waddr = sel_idx;
                    fho_wdata = NOT_FREE;
                    al_we     = 1'b1;
                    al_waddr  = sel_idx;
                    al_wdata  = 1'b1;
                    free_cnt_next = ({1'b0, free_cnt_reg} > blk_pages)
                                    ? (free_cnt_reg - blk_pages[CNT_W-1:0]) : '0;
                    idx_next  = sel_idx;
                    cur_next  = sel_ord;
                    page_next = live_start_reg + 20'(sel_idx);
                    if (sel_ord == ord_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end

            S_SPLIT:
            begin
                // Release the upper half at each lower order.
                if (split_b < live_pages_reg)
                begin
                    fho_we    = 1'b1;
                    fho_waddr = split_b[IDX_W-1:0];
                    fho_wdata = cm1;
                end
                cur_next = cm1;
                if (cm1 == ord_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end

            S_FCHK:
            begin
                if (!al_rdata)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOTHEAD;
                    page_next   = 20'd0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    al_we     = 1'b1;
                    al_wdata  = 1'b0;
                    fho_we    = 1'b1;
                    fho_wdata = NOT_FREE;
                    free_cnt_next = (cnt_sum > 14'(CNT_MAX)) ? CNT_MAX
                                                             : cnt_sum[CNT_W-1:0];
                    cur_next   = ord_reg;
                    state_next = S_MREAD;
                end
            end

            S_MREAD:
            begin
                fho_raddr = bud[IDX_W-1:0];
                if ((cur_reg < TOP_ORD) && (bud < live_pages_reg))
                begin
                    state_next = S_MWAIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_MWAIT:
            begin
                if (fho_rdata == cur_reg)
                begin
                    // The buddy is free at this order: take it in and go up.
                    fho_we     = 1'b1;
                    fho_waddr  = bud[IDX_W-1:0];
                    fho_wdata  = NOT_FREE;
                    idx_next   = idx_reg & bud[IDX_W-1:0];
                    cur_next   = cur_reg + ORD_W'(1);
                    state_next = S_MREAD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                fho_we      = 1'b1;
                fho_wdata   = cur_reg;
                done_next   = 1'b1;
                status_next = ST_OK;
                page_next   = 20'd0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            rvld_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            done_reg       <= 1'b0;
            live_start_reg <= 20'd0;
            live_pages_reg <= LIV_W'(RST_LIVE);
            free_cnt_reg   <= CNT_W'(RST_FREE);
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            rvld_reg  <= rvld_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if ((state_reg == S_IDLE) && start && (op == OP_REINIT))
            begin
                live_start_reg <= cfg_start_reg;
                live_pages_reg <= new_live;
                free_cnt_reg   <= (32'(new_live) > 8191) ? CNT_MAX : CNT_W'(new_live);
            end
            else
            begin
                free_cnt_reg <= free_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg      <= rq_next;
        ord_reg     <= ord_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        lo_fnd_reg  <= lo_fnd_next;
        lo_idx_reg  <= lo_idx_next;
        hi_idx_reg  <= hi_idx_next;
        status_reg  <= status_next;
        page_reg    <= page_next;
    end

    // A result is only raised once the block is back in idle.
    `ASSERT_CLK(a_done_idle, done_reg |-> (state_reg == S_IDLE), "result outside idle")
    // Splitting only happens while the current order is above the asked one.
    `ASSERT_CLK(a_split_ord, (state_reg == S_SPLIT) |-> (cur_reg > ord_reg), "split below order")
    // Scan read data only comes back during the scan.
    `ASSERT_CLK(a_rvld_scan, rvld_reg |-> (state_reg == S_SCAN), "stray scan data")
    // A merge never climbs past the top order.
    `ASSERT_CLK(a_merge_top, (state_reg == S_MWAIT) |-> (cur_reg < TOP_ORD), "merge past top")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the buddy page allocator core.
`timescale 1ns / 1ps

// Holds the expected results of accepted requests in arrival order.
class alloc_scoreboard;
    bpa_pkg::status_t want_status[$];
    logic [19:0]      want_page[$];
    logic [12:0]      want_free[$];
    int               errors;

    function new();
        errors = 0;
    endfunction

    function void note_request(bpa_pkg::status_t st, logic [19:0] pg, logic [12:0] fr);
        want_status.push_back(st);
        want_page.push_back(pg);
        want_free.push_back(fr);
    endfunction

    function int pending();
        return want_status.size();
    endfunction

    function void check_result(logic [1:0] st, logic [19:0] pg, logic [12:0] fr);
        bpa_pkg::status_t es;
        logic [19:0]      ep;
        logic [12:0]      ef;
        if (want_status.size() == 0)
        begin
            $error("result with no request waiting: status %0d page %0d", st, pg);
            errors++;
            return;
        end
        es = want_status.pop_front();
        ep = want_page.pop_front();
        ef = want_free.pop_front();
        if (st !== es)
        begin
            $error("status: expected %0d, actual %0d", es, st);
            errors++;
        end
        if (pg !== ep)
        begin
            $error("alloc_page: expected %0d, actual %0d", ep, pg);
            errors++;
        end
        if (fr !== ef)
        begin
            $error("free_pages_total: expected %0d, actual %0d", ef, fr);
            errors++;
        end
    endfunction
endclass

module testbench;
    import bpa_pkg::*;

    localparam int TOP_ORD    = 4;
    localparam int POOL       = 4096;
    localparam int MAX_TOPS   = POOL >> TOP_ORD;
    localparam int NOT_FREE   = 255;
    localparam int WATCHDOG   = 40000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [3:0]  order;
    logic [19:0] page_number;
    logic        done;
    logic [1:0]  status;
    logic [19:0] alloc_page;
    logic [12:0] free_pages_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [19:0] cfg_data;

    buddy_page_allocator_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .order            (order),
        .page_number      (page_number),
        .done             (done),
        .status           (status),
        .alloc_page       (alloc_page),
        .free_pages_total (free_pages_total),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predictor state: a mirror of the pool as the block should hold it.
    int          head_ord [POOL];
    bit          alloc_head [POOL];
    int          cnt_per_ord [TOP_ORD + 1];
    int          pages_free;
    logic [19:0] reg_start;
    logic [8:0]  reg_tops;
    int          pool_base;
    int          pool_len;

    // Heads of blocks we allocated, with their order, so frees mostly hit.
    int          held_page[$];
    int          held_ord[$];

    alloc_scoreboard sb;
    int              idle_pct;
    int              quiet_cycles;

    function automatic int sat_up(int a, int b);
        return (a + b > 8191) ? 8191 : a + b;
    endfunction

    function automatic int sat_down(int a, int b);
        return (a > b) ? a - b : 0;
    endfunction

    // Latches the registers and marks every top block free.
    function automatic void pool_rebuild();
        int tops;
        tops = (reg_tops > MAX_TOPS) ? MAX_TOPS : reg_tops;
        pool_base = reg_start;
        pool_len  = tops << TOP_ORD;
        for (int i = 0; i < POOL; i++)
        begin
            head_ord[i]   = NOT_FREE;
            alloc_head[i] = 1'b0;
        end
        for (int o = 0; o <= TOP_ORD; o++)
            cnt_per_ord[o] = 0;
        for (int t = 0; t < tops; t++)
            head_ord[t << TOP_ORD] = TOP_ORD;
        cnt_per_ord[TOP_ORD] = tops;
        pages_free = pool_len;
        held_page.delete();
        held_ord.delete();
    endfunction

    function automatic status_t pool_alloc(int ord, output logic [19:0] pg);
        int  cur;
        int  idx;
        int  split_ord;
        bit  found;
        found = 0;
        idx   = 0;
        cur   = ord;
        pg    = '0;
        for (cur = ord; cur <= TOP_ORD; cur++)
        begin
            for (int i = 0; i < pool_len; i++)
            begin
                if (head_ord[i] == cur)
                begin
                    idx   = i;
                    found = 1;
                    // An exact hit above order 0 keeps going to the highest block.
                    if (!(cur == ord && ord > 0))
                        break;
                end
            end
            if (found)
                break;
        end
        if (!found)
            return ST_NOFREE;
        head_ord[idx]    = NOT_FREE;
        cnt_per_ord[cur] = sat_down(cnt_per_ord[cur], 1);
        alloc_head[idx]  = 1'b1;
        pages_free       = sat_down(pages_free, 1 << ord);
        split_ord        = cur;
        while (split_ord > ord)
        begin
            split_ord--;
            if (idx + (1 << split_ord) < pool_len)
            begin
                head_ord[idx + (1 << split_ord)] = split_ord;
                cnt_per_ord[split_ord] = sat_up(cnt_per_ord[split_ord], 1);
            end
        end
        pg = 20'(pool_base + idx);
        return ST_OK;
    endfunction

    function automatic status_t pool_free(int ord, int pn);
        int idx;
        int bud;
        if (pn < pool_base || pn - pool_base >= pool_len)
            return ST_BADARG;
        idx = pn - pool_base;
        if ((idx & ((1 << ord) - 1)) != 0)
            return ST_BADARG;
        if (!alloc_head[idx])
            return ST_NOTHEAD;
        alloc_head[idx] = 1'b0;
        pages_free = sat_up(pages_free, 1 << ord);
        while (ord < TOP_ORD)
        begin
            bud = idx ^ (1 << ord);
            if (bud >= pool_len || head_ord[bud] != ord)
                break;
            head_ord[bud] = NOT_FREE;
            head_ord[idx] = NOT_FREE;
            cnt_per_ord[ord] = sat_down(cnt_per_ord[ord], 1);
            idx &= bud;
            ord++;
        end
        head_ord[idx] = ord;
        cnt_per_ord[ord] = sat_up(cnt_per_ord[ord], 1);
        return ST_OK;
    endfunction

    // Works out the result of one accepted request and queues it.
    function automatic void predict_request(op_t o, int ord, int pn);
        status_t     st;
        logic [19:0] pg;
        pg = '0;
        st = ST_BADARG;
        if (o == OP_REINIT)
        begin
            pool_rebuild();
            st = ST_OK;
        end
        else if (o != OP_BAD && ord <= TOP_ORD)
        begin
            if (o == OP_ALLOC)
            begin
                st = pool_alloc(ord, pg);
                if (st == ST_OK)
                begin
                    held_page.push_back(pg);
                    held_ord.push_back(ord);
                end
            end
            else
            begin
                st = pool_free(ord, pn);
            end
        end
        if (st != ST_OK)
            pg = '0;
        sb.note_request(st, pg, 13'(pages_free));
    endfunction

    // Results cannot be stalled, so every done cycle is checked here.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, alloc_page, free_pages_total);
    end

    // Watchdog on cycles in which no transaction of any kind completes.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Sends one request, after a random gap, and holds start until busy is seen low.
    task automatic send_request(op_t o, int ord, int pn);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start       <= 1'b1;
        op          <= o;
        order       <= 4'(ord);
        page_number <= 20'(pn);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(o, ord, pn);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_START)
            reg_start = val;
        else
            reg_tops = val[8:0];
        @(posedge clk);
    endtask

    // Waits until every queued result has arrived, then lets the block settle.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (64)
            @(posedge clk);
    endtask

    // Frees a block we hold, or with some chance an arbitrary or damaged one.
    task automatic random_free();
        int k;
        int pn;
        int ord;
        if (held_page.size() != 0 && $urandom_range(99) < 80)
        begin
            k   = $urandom_range(held_page.size() - 1);
            pn  = held_page[k];
            ord = held_ord[k];
            held_page.delete(k);
            held_ord.delete(k);
            // Occasionally the wrong order, which the block trusts as given.
            if ($urandom_range(99) < 5)
                ord = $urandom_range(TOP_ORD);
        end
        else
        begin
            ord = $urandom_range(15);
            case ($urandom_range(2))
                0: pn = $urandom_range(20'hFFFFF);
                1: pn = pool_base + $urandom_range(pool_len + 15);
                default: pn = pool_base + ($urandom_range(pool_len) & ~15);
            endcase
        end
        send_request(OP_FREE, ord, pn);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(999);
        if (r < 500)
            send_request(OP_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(15)
                                                             : $urandom_range(TOP_ORD),
                         $urandom_range(20'hFFFFF));
        else if (r < 960)
            random_free();
        else if (r < 985)
            send_request(OP_BAD, $urandom_range(15), $urandom_range(20'hFFFFF));
        else
            send_request(OP_REINIT, $urandom_range(15), $urandom_range(20'hFFFFF));
    endtask

    // Changes the pool layout while idle and starts it with a reinitialise.
    task automatic reconfigure(logic [19:0] base, logic [19:0] tops);
        wait_drained();
        write_register(CFG_START, base);
        write_register(CFG_TOPS, tops);
        send_request(OP_REINIT, 0, 0);
    endtask

    initial
    begin
        sb           = new();
        quiet_cycles = 0;
        idle_pct     = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_ALLOC;
        order        = '0;
        page_number  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_START;
        cfg_data     = '0;
        reg_start    = '0;
        reg_tops     = 9'd256;
        pool_rebuild();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset layout: every op, edge orders and frees.
        send_request(OP_ALLOC, 0, 20'hFFFFF);
        send_request(OP_ALLOC, TOP_ORD, 0);
        send_request(OP_ALLOC, 2, 0);
        send_request(OP_ALLOC, 15, 0);
        send_request(OP_ALLOC, TOP_ORD + 1, 0);
        send_request(OP_BAD, 0, 0);
        send_request(OP_FREE, 0, 20'hFFFFF);
        send_request(OP_FREE, 1, 1);
        send_request(OP_FREE, 0, 5);
        send_request(OP_FREE, 15, 0);
        send_request(OP_FREE, 3, 8);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 2, 4088);
        send_request(OP_FREE, TOP_ORD, 4080);
        send_request(OP_REINIT, 15, 20'hFFFFF);

        // Small pool at the top of the page space: exhaustion and merging.
        reconfigure(20'hFFFE0, 2);
        for (int i = 0; i < 34; i++)
            send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 20'hFFFE0);
        send_request(OP_FREE, 0, 20'hFFFE1);
        // Too many top blocks are clamped; an empty pool has nothing to give.
        reconfigure(20'h00000, 20'h001FF);
        send_request(OP_ALLOC, 0, 0);
        reconfigure(20'h00010, 0);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 20'h00010);
        send_request(OP_ALLOC, 0, 0);

        // Random phases over several layouts and idling levels.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 70;
                2: idle_pct = 28;
                default: idle_pct = 0;
            endcase
            case (ph)
                0: reconfigure(20'h00000, 4);
                1: reconfigure(20'h12340 | 20'($urandom_range(15) << 4), 3);
                2: reconfigure(20'hFFF00, 16);
                3: reconfigure(20'(($urandom_range(20'hFFFFF)) & ~15), 1);
                4: reconfigure(20'h00000, 256);
                5: reconfigure(20'h55550, 20'($urandom_range(8)));
                6: reconfigure(20'hAAAA0, 6);
                default: reconfigure(20'h00000, 2);
            endcase
            // Every allocation scans the whole live pool, so the large pool phase sends fewer requests.
            for (int i = 0; i < ((ph == 4) ? 40 : 205); i++)
                random_request();
            // Hold off until the block has answered everything.
            wait_drained();
        end

        idle_pct = 0;
        wait_drained();
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
